// ===== rtl/core/ple_pkg.sv =====
package ple_pkg;

  // default sizes
  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // fixed field widths
  localparam int POS_W  = 7;
  localparam int IDX_W  = 6;
  localparam int DATA_W = 32;
  localparam int EXT_W  = 64;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_READ   = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    req_kind_t                 req_type;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  item_value;
  } in_word_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  read_value;
    logic [IDX_W-1:0]          read_index;
    logic                      last_of_run;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_INS_WR,
    S_INS_LINK,
    S_DEL_HEAD,
    S_DEL_SEL,
    S_DEL_FIX,
    S_READ,
    S_RESP
  } ple_state_t;

endpackage

// ===== rtl/core/positional_list_engine.sv =====
// Insert or delete at index p > 0 walks p - 1 links, one per cycle through the registered
// link read port, before the status word; append walks the same way with p the list length.
// Head insert or delete skips the walk, and a refused request goes straight to the status word.
// A read of n elements gives n words, one per cycle while the output does not stall.
// A new request is taken only once the engine is back in idle after the last word.
// Reset: synchronous rst_n empties the list; free slots read in order via per-entry valid bits.
module positional_list_engine #(
  parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ple_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ple_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ple_pkg::out_word_t out_word
);
  import ple_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // node and free-slot memories
  logic [VALUE_BITS-1:0] val_mem  [CAPACITY];
  logic [SW-1:0]         link_mem [CAPACITY];
  logic [SW-1:0]         free_mem [CAPACITY];
  logic [CAPACITY-1:0]   fv_r;

  // control registers
  ple_state_t      state_r, state_nxt;
  logic [SW-1:0]   head_r, head_nxt;
  logic [SW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            out_valid_r;

  // payload registers
  req_kind_t              kind_r;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [VALUE_BITS-1:0]  val_r;
  status_t                status_r, status_nxt;
  logic [SW-1:0]          cur_r, cur_nxt;
  logic [SW-1:0]          slot_r, slot_nxt;
  logic [CW-1:0]          steps_r, steps_nxt;
  logic                   first_r, first_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  out_word_t              out_word_r, out_word_nxt;

  // memory read data
  logic [VALUE_BITS-1:0]  val_rd_r;
  logic [SW-1:0]          link_rd_r;
  logic [SW-1:0]          free_rd_r;
  logic                   free_vld_r;
  logic [SW-1:0]          free_idx_r;

  // memory controls
  logic                   val_we, val_re;
  logic [SW-1:0]          val_waddr, val_raddr;
  logic                   link_we, link_re;
  logic [SW-1:0]          link_waddr, link_raddr, link_wdata;
  logic                   free_we, free_re;
  logic [SW-1:0]          free_waddr, free_wdata, free_raddr;

  // helpers
  logic                   in_take, out_free, out_load;
  logic [POS_W-1:0]       pos_eff, count_ext;
  logic [POS_W-1:0]       pos_m1;
  logic [CW-1:0]          count_m1;
  logic [SW-1:0]          cur_c, free_slot_c;
  logic                   is_ins, read_last;
  logic signed [EXT_W-1:0] item_ext;
  logic [EXT_W-1:0]       rv_wide;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign count_ext   = POS_W'(count_r);
  assign count_m1    = count_r - CW'(1);
  assign is_ins      = (kind_r == REQ_INSERT) || (kind_r == REQ_APPEND);
  assign pos_eff     = (kind_r == REQ_APPEND) ? count_ext : pos_r;
  assign pos_m1      = pos_eff - POS_W'(1);
  assign cur_c       = first_r ? cur_r : link_rd_r;
  assign free_slot_c = free_vld_r ? free_rd_r : free_idx_r;
  assign read_last   = ({1'b0, idx_r} + POS_W'(1)) == count_ext;
  assign item_ext    = EXT_W'(in_word.item_value);
  assign rv_wide     = EXT_W'(val_rd_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (is_ins) begin
          priority if (count_r == CW'(CAPACITY)) state_nxt = S_RESP;
          else if (pos_eff > count_ext)          state_nxt = S_RESP;
          else if (count_r == '0 || pos_eff == '0) state_nxt = S_INS_WR;
          else                                   state_nxt = S_WALK;
        end else if (kind_r == REQ_DELETE) begin
          priority if (count_r == '0)       state_nxt = S_RESP;
          else if (pos_r >= count_ext)      state_nxt = S_RESP;
          else if (pos_r == '0)             state_nxt = S_DEL_HEAD;
          else                              state_nxt = S_WALK;
        end else begin
          if (count_r == '0) state_nxt = S_RESP;
          else               state_nxt = S_READ;
        end
      end
      S_WALK: begin
        if (steps_r == '0) state_nxt = (kind_r == REQ_DELETE) ? S_DEL_SEL : S_INS_WR;
      end
      S_INS_WR: begin
        if (count_r == '0 || pos_r == '0) state_nxt = S_RESP;
        else                               state_nxt = S_INS_LINK;
      end
      S_INS_LINK: state_nxt = S_RESP;
      S_DEL_HEAD: state_nxt = S_RESP;
      S_DEL_SEL:  state_nxt = S_DEL_FIX;
      S_DEL_FIX:  state_nxt = S_RESP;
      S_READ: begin
        if (out_free && read_last) state_nxt = S_IDLE;
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    status_nxt   = status_r;
    cur_nxt      = cur_r;
    slot_nxt     = slot_r;
    steps_nxt    = steps_r;
    first_nxt    = first_r;
    idx_nxt      = idx_r;
    out_load     = 1'b0;
    out_word_nxt = out_word_r;
    val_we       = 1'b0;
    val_waddr    = free_slot_c;
    val_re       = 1'b0;
    val_raddr    = head_r;
    link_we      = 1'b0;
    link_waddr   = cur_r;
    link_wdata   = link_rd_r;
    link_re      = 1'b0;
    link_raddr   = head_r;
    free_we      = 1'b0;
    free_waddr   = count_m1[SW-1:0];
    free_wdata   = slot_r;
    free_re      = 1'b0;
    free_raddr   = count_r[SW-1:0];
    unique case (state_r)
      S_IDLE: begin
      end
      S_DECIDE: begin
        pos_nxt    = pos_eff;
        status_nxt = ST_OK;
        cur_nxt    = head_r;
        first_nxt  = 1'b1;
        steps_nxt  = CW'(pos_m1);
        idx_nxt    = '0;
        priority if (is_ins) begin
          priority if (count_r == CW'(CAPACITY)) status_nxt = ST_FULL;
          else if (pos_eff > count_ext)          status_nxt = ST_INVALID;
          else                                   free_re    = 1'b1;
        end else if (kind_r == REQ_DELETE) begin
          priority if (count_r == '0)  status_nxt = ST_EMPTY;
          else if (pos_r >= count_ext) status_nxt = ST_INVALID;
          else                         link_re    = 1'b1;
        end else begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            val_re  = 1'b1;
            link_re = 1'b1;
          end
        end
      end
      // follow one link per cycle; the read at the target fetches its link
      S_WALK: begin
        link_re    = 1'b1;
        link_raddr = cur_c;
        first_nxt  = 1'b0;
        if (steps_r == '0) cur_nxt = cur_c;
        else               steps_nxt = steps_r - CW'(1);
      end
      // write the new node into the slot taken from the free stack
      S_INS_WR: begin
        val_we     = 1'b1;
        link_we    = 1'b1;
        link_waddr = free_slot_c;
        slot_nxt   = free_slot_c;
        count_nxt  = count_r + CW'(1);
        priority if (count_r == '0) begin
          link_wdata = '0;
          head_nxt   = free_slot_c;
          tail_nxt   = free_slot_c;
        end else if (pos_r == '0) begin
          link_wdata = head_r;
          head_nxt   = free_slot_c;
        end else begin
          link_wdata = link_rd_r;
        end
      end
      // hook the new node behind its predecessor
      S_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = slot_r;
        if (cur_r == tail_r) tail_nxt = slot_r;
      end
      // unlink the head and return its slot
      S_DEL_HEAD: begin
        head_nxt   = link_rd_r;
        free_we    = 1'b1;
        free_wdata = head_r;
        count_nxt  = count_m1;
        if (count_m1 == '0) begin
          head_nxt = '0;
          tail_nxt = '0;
        end
      end
      // victim is the predecessor's successor; fetch its link
      S_DEL_SEL: begin
        slot_nxt   = link_rd_r;
        link_re    = 1'b1;
        link_raddr = link_rd_r;
      end
      S_DEL_FIX: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = link_rd_r;
        if (slot_r == tail_r) tail_nxt = cur_r;
        free_we    = 1'b1;
        free_wdata = slot_r;
        count_nxt  = count_m1;
      end
      // one element word per cycle while the output is not stalled, next node fetched alongside
      S_READ: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_word_nxt = '{status: ST_OK,
                            read_value: signed'(rv_wide[DATA_W-1:0]),
                            read_index: idx_r,
                            last_of_run: read_last};
          if (!read_last) begin
            val_re     = 1'b1;
            val_raddr  = link_rd_r;
            link_re    = 1'b1;
            link_raddr = link_rd_r;
            idx_nxt    = idx_r + IDX_W'(1);
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_word_nxt = '{status: status_r, read_value: '0, read_index: '0,
                            last_of_run: 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      fv_r        <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (out_load)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (free_we) fv_r[free_waddr] <= 1'b1;
    end
  end

  // request and working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r <= in_word.req_type;
      pos_r  <= in_word.position;
      val_r  <= item_ext[VALUE_BITS-1:0];
    end else begin
      pos_r <= pos_nxt;
    end
    status_r <= status_nxt;
    cur_r    <= cur_nxt;
    slot_r   <= slot_nxt;
    steps_r  <= steps_nxt;
    first_r  <= first_nxt;
    idx_r    <= idx_nxt;
    if (out_load) out_word_r <= out_word_nxt;
  end

  // node value memory
  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_waddr] <= val_r;
    if (val_re) val_rd_r <= val_mem[val_raddr];
  end

  // node link memory
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (link_re) link_rd_r <= link_mem[link_raddr];
  end

  // free-slot stack; an entry never written reads as its own index
  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_waddr] <= free_wdata;
    if (free_re) begin
      free_rd_r  <= free_mem[free_raddr];
      free_vld_r <= fv_r[free_raddr];
      free_idx_r <= free_raddr;
    end
  end

endmodule
